[rtl/core/single_wire_rgb_led_serializer_defines.svh]
// Assertion macros used by the checker file of the serializer.
`ifndef SINGLE_WIRE_RGB_LED_SERIALIZER_DEFINES_SVH
`define SINGLE_WIRE_RGB_LED_SERIALIZER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define SWLED_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("serializer check failed in the same cycle");

// Next-cycle implication, disabled while reset is held.
`define SWLED_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("serializer check failed one cycle later");

`endif

[rtl/core/swled_pkg.sv]
package swled_pkg;

  // Write command that opens every LED frame.
  localparam logic [7:0] WRITE_CMD      = 8'h3A;
  // Bit and period lengths in fifths of a bit cycle, and the number of bits per frame.
  localparam logic [5:0] FIFTHS_PER_BIT = 6'd5;
  localparam logic [5:0] BITS_PER_LED   = 6'd32;
  localparam logic [5:0] EOS_FIFTHS     = 6'd20;
  localparam logic [5:0] LATCH_FIFTHS   = 6'd40;
  // Reset value of the ticks-per-fifth register.
  localparam logic [15:0] TPF_RESET     = 16'd100;

  // One classified input word.
  typedef struct packed {
    logic       is_load;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_led;
  } swled_item_t;

  // Queue status seen by the front and back parts.
  typedef struct packed {
    logic full;
    logic empty;
  } swled_q_stat_t;

endpackage

[rtl/core/swled_front.sv]
module swled_front
  import swled_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          in_req_type,
  input  logic [7:0]    in_red,
  input  logic [7:0]    in_green,
  input  logic [7:0]    in_blue,
  input  logic          in_last_led,
  input  swled_q_stat_t q_stat,
  output logic          push,
  output swled_item_t   push_item
);

  logic        front_valid_r;
  logic        front_valid_nxt;
  swled_item_t item_r;
  logic        take;

  // The input register may refill whenever its word moves on to the queue.
  assign push     = front_valid_r && !q_stat.full;
  assign in_stall = front_valid_r && q_stat.full;
  assign take     = in_valid && !in_stall;

  assign push_item = item_r;

  always_comb begin
    front_valid_nxt = front_valid_r;
    if (take) begin
      front_valid_nxt = 1'b1;
    end else if (push) begin
      front_valid_nxt = 1'b0;
    end
  end

  // Classify the word as tick or load and capture its colour fields.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_valid_r <= 1'b0;
    end else begin
      front_valid_r <= front_valid_nxt;
    end
    if (take) begin
      item_r.is_load  <= in_req_type;
      item_r.red      <= in_red;
      item_r.green    <= in_green;
      item_r.blue     <= in_blue;
      item_r.last_led <= in_last_led;
    end
  end

endmodule

[rtl/core/swled_queue.sv]
module swled_queue
  import swled_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  swled_item_t   push_item,
  input  logic          pop,
  output swled_item_t   head_item,
  output swled_q_stat_t q_stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  swled_item_t   entry_r [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r;
  logic [PW-1:0] rd_ptr_nxt;
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;

  assign q_stat.full  = (count_r == CW'(DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign head_item    = entry_r[rd_ptr_r];

  // Pointers wrap at the queue depth, which need not be a power of two.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

[rtl/core/swled_back.sv]
module swled_back
  import swled_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [15:0]   cfg_wdata,
  input  swled_item_t   head_item,
  input  swled_q_stat_t q_stat,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic          out_line_level,
  output logic          out_load_accepted,
  output logic          out_busy_res,
  output logic          out_latch_done
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_BITS,
    PH_EOS,
    PH_LATCH
  } phase_t;

  // Line state.
  phase_t        phase_r, phase_nxt;
  logic [31:0]   shift_r, shift_nxt;
  logic [5:0]    bits_r, bits_nxt;
  logic [5:0]    fifths_r, fifths_nxt;
  logic [15:0]   ticks_r, ticks_nxt;
  logic          cur_last_r, cur_last_nxt;
  logic [24:0]   hold_word_r, hold_word_nxt;
  logic          hold_valid_r, hold_valid_nxt;
  logic [15:0]   tpf_r;

  // Output register.
  logic          out_valid_r, out_valid_nxt;
  logic          level_r, level_nxt;
  logic          accepted_r, accepted_nxt;
  logic          busy_r, busy_nxt;
  logic          latch_r, latch_nxt;

  // Working values after a possible frame start.
  phase_t        eff_phase;
  logic [31:0]   eff_shift;
  logic [5:0]    eff_bits;
  logic [5:0]    eff_fifths;
  logic          eff_last;
  logic [15:0]   tick_inc;
  logic [15:0]   limit;
  logic [5:0]    fifths_dec;
  logic [5:0]    bits_dec;

  // A word is worked on when the output register is free or being emptied.
  assign pop = !q_stat.empty && (!out_valid_r || !out_stall);

  assign out_valid         = out_valid_r;
  assign out_line_level    = level_r;
  assign out_load_accepted = accepted_r;
  assign out_busy_res      = busy_r;
  assign out_latch_done    = latch_r;

  assign limit = (tpf_r == 16'd0) ? 16'd1 : tpf_r;

  // Per-word state update: a load fills the holding register if it is free, a tick advances time.
  always_comb begin
    phase_nxt      = phase_r;
    shift_nxt      = shift_r;
    bits_nxt       = bits_r;
    fifths_nxt     = fifths_r;
    ticks_nxt      = ticks_r;
    cur_last_nxt   = cur_last_r;
    hold_word_nxt  = hold_word_r;
    hold_valid_nxt = hold_valid_r;
    level_nxt      = level_r;
    accepted_nxt   = accepted_r;
    busy_nxt       = busy_r;
    latch_nxt      = latch_r;
    eff_phase      = phase_r;
    eff_shift      = shift_r;
    eff_bits       = bits_r;
    eff_fifths     = fifths_r;
    eff_last       = cur_last_r;
    tick_inc       = 16'd0;
    fifths_dec     = 6'd0;
    bits_dec       = 6'd0;

    if (pop && head_item.is_load) begin
      accepted_nxt = 1'b0;
      if (!hold_valid_r) begin
        hold_word_nxt  = {head_item.red, head_item.green, head_item.blue, head_item.last_led};
        hold_valid_nxt = 1'b1;
        accepted_nxt   = 1'b1;
      end
      level_nxt = (phase_r == PH_BITS) &&
                  ((fifths_r == FIFTHS_PER_BIT) || ((fifths_r == 6'd3) && shift_r[31]));
      busy_nxt  = (phase_r != PH_IDLE);
      latch_nxt = 1'b0;
    end else if (pop) begin
      ticks_nxt = ticks_r;
      // An idle line with a held LED starts its frame on this very tick.
      if ((phase_r == PH_IDLE) && hold_valid_r) begin
        eff_shift      = {WRITE_CMD, hold_word_r[24:1]};
        eff_last       = hold_word_r[0];
        hold_valid_nxt = 1'b0;
        eff_bits       = BITS_PER_LED;
        eff_phase      = PH_BITS;
        eff_fifths     = FIFTHS_PER_BIT;
        ticks_nxt      = 16'd0;
      end
      level_nxt    = (eff_phase == PH_BITS) &&
                     ((eff_fifths == FIFTHS_PER_BIT) ||
                      ((eff_fifths == 6'd3) && eff_shift[31]));
      busy_nxt     = (eff_phase != PH_IDLE);
      accepted_nxt = 1'b0;
      latch_nxt    = 1'b0;
      phase_nxt    = eff_phase;
      shift_nxt    = eff_shift;
      bits_nxt     = eff_bits;
      fifths_nxt   = eff_fifths;
      cur_last_nxt = eff_last;

      if (eff_phase != PH_IDLE) begin
        tick_inc  = ticks_nxt + 16'd1;
        ticks_nxt = tick_inc;
        // End of one fifth of the bit cycle.
        if ((tick_inc >= limit) || (tick_inc == 16'd0)) begin
          ticks_nxt  = 16'd0;
          fifths_dec = (eff_fifths != 6'd0) ? eff_fifths - 6'd1 : 6'd0;
          fifths_nxt = fifths_dec;
          if (eff_phase == PH_BITS) begin
            if (fifths_dec == 6'd0) begin
              shift_nxt = {eff_shift[30:0], 1'b0};
              bits_dec  = (eff_bits != 6'd0) ? eff_bits - 6'd1 : 6'd0;
              bits_nxt  = bits_dec;
              if (bits_dec == 6'd0) begin
                phase_nxt  = eff_last ? PH_LATCH : PH_EOS;
                fifths_nxt = eff_last ? LATCH_FIFTHS : EOS_FIFTHS;
              end else begin
                fifths_nxt = FIFTHS_PER_BIT;
              end
            end
          end else if (fifths_dec == 6'd0) begin
            latch_nxt = (eff_phase == PH_LATCH);
            phase_nxt = PH_IDLE;
          end
        end
      end
    end
  end

  // The output register holds its word while the receiver stalls.
  always_comb begin
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      shift_r      <= '0;
      bits_r       <= '0;
      fifths_r     <= '0;
      ticks_r      <= '0;
      cur_last_r   <= 1'b0;
      hold_valid_r <= 1'b0;
      tpf_r        <= TPF_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      shift_r      <= shift_nxt;
      bits_r       <= bits_nxt;
      fifths_r     <= fifths_nxt;
      ticks_r      <= ticks_nxt;
      cur_last_r   <= cur_last_nxt;
      hold_valid_r <= hold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        tpf_r <= cfg_wdata;
      end
    end
    hold_word_r <= hold_word_nxt;
    level_r     <= level_nxt;
    accepted_r  <= accepted_nxt;
    busy_r      <= busy_nxt;
    latch_r     <= latch_nxt;
  end

endmodule

[rtl/core/single_wire_rgb_led_serializer.sv]
// One-wire RGB LED chain serializer. Each input word is either a tick, which advances the
// line timing by one clock of the timing base, or a load, which offers one LED's red, green
// and blue bytes and a last-LED flag to a one-entry holding register; every input word
// returns exactly one result word with the line level, whether a load was taken, the busy
// flag and a latch-done pulse. A frame is the command 0x3A and the three colour bytes, most
// significant bit first, each bit five fifths long, followed by an end-of-sequence or latch
// low period. Words are taken at one per clock cycle while out_stall is low: the back part
// updates the whole line state in a single cycle per word, and the input register, the
// queue of QUEUE_DEPTH entries and the output register lie between a word and its result.
// ticks_per_fifth resets to 100; the user must write it only while idle, unenforced by the block.
module single_wire_rgb_led_serializer
  import swled_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic        in_last_led,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_line_level,
  output logic        out_load_accepted,
  output logic        out_busy_res,
  output logic        out_latch_done
);

  swled_q_stat_t q_stat;
  swled_item_t   push_item;
  swled_item_t   head_item;
  logic          push;
  logic          pop;

  // Front part: input register and word classification.
  swled_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_req_type (in_req_type),
    .in_red      (in_red),
    .in_green    (in_green),
    .in_blue     (in_blue),
    .in_last_led (in_last_led),
    .q_stat      (q_stat),
    .push        (push),
    .push_item   (push_item)
  );

  // Short queue that decouples the two parts.
  swled_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .q_stat    (q_stat)
  );

  // Back part: line timing, holding register and output register.
  swled_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .head_item         (head_item),
    .q_stat            (q_stat),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_line_level    (out_line_level),
    .out_load_accepted (out_load_accepted),
    .out_busy_res      (out_busy_res),
    .out_latch_done    (out_latch_done)
  );

endmodule

[rtl/core/swled_checker.sv]
`include "single_wire_rgb_led_serializer_defines.svh"

module swled_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_stall,
  input logic out_line_level,
  input logic out_load_accepted,
  input logic out_busy_res,
  input logic out_latch_done
);

  // A word is either a load or a tick, so it never both takes a load and ends a latch.
  `SWLED_ASSERT_NOW(a_load_xor_latch, clk, rst_n, out_valid, !(out_load_accepted && out_latch_done))

  // The line is low while nothing is being sent.
  `SWLED_ASSERT_NOW(a_idle_low, clk, rst_n, out_valid && !out_busy_res, !out_line_level)

  // The tick that ends a latch falls in a low period of a busy line.
  `SWLED_ASSERT_NOW(a_latch_low, clk, rst_n, out_valid && out_latch_done, out_busy_res && !out_line_level)

  // A stalled result word stays offered.
  `SWLED_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)

endmodule

bind single_wire_rgb_led_serializer swled_checker u_swled_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_line_level    (out_line_level),
  .out_load_accepted (out_load_accepted),
  .out_busy_res      (out_busy_res),
  .out_latch_done    (out_latch_done)
);
